@@ src/smpq_pkg.sv @@
// types and constants shared by the sorted minimum priority queue
`default_nettype none

package smpq_pkg;

    localparam int FIELD_W       = 32;
    localparam int COUNT_FIELD_W = 5;

    localparam logic KIND_INSERT  = 1'b0;
    localparam logic KIND_EXTRACT = 1'b1;

    typedef struct packed {
        logic                       kind;
        logic signed [FIELD_W-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic signed [FIELD_W-1:0]  removed_value;
        logic                       removed_valid;
        logic signed [FIELD_W-1:0]  min_value;
        logic                       is_empty;
        logic [COUNT_FIELD_W-1:0]   entry_count;
        logic                       overflow;
    } t_out_item;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic ext;
    } t_cell_cmd;

endpackage

`default_nettype wire

@@ src/sorted_min_priority_queue.sv @@
// top level of the sorted minimum priority queue: chain of cells and result register
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+------------------------
//  command  | in        | start high while busy low   | i_item  (kind, value)
//  result   | out       | o_result_valid, one cycle   | o_result (six fields)
//
// one command per clock; its result shows the cycle after it is taken
// every cell compares against the new value and shifts in the same edge, so the
// whole chain moves together and busy never rises
// reset clears the entry count and the result strobe; entries are not cleared
// the receiver cannot stall: each result beat lasts exactly one cycle
`default_nettype none

module sorted_min_priority_queue #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    start,
    output logic                   busy,
    input  smpq_pkg::t_in_item     i_item,
    output logic                   o_result_valid,
    output smpq_pkg::t_out_item    o_result
);
    import smpq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    // entry count and registered result fields
    logic [CW-1:0]          r_count, n_count;
    logic                   r_strobe;
    logic [VALUE_WIDTH-1:0] r_removed;
    logic                   r_removed_valid;
    logic                   r_overflow;

    logic [VALUE_WIDTH-1:0] new_value;
    t_cell_cmd              cmd;
    logic                   is_insert;
    logic                   is_extract;
    logic                   take;

    logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
    logic                   cell_ge    [DEPTH];

    // every command is taken at once, so busy is never raised
    assign busy = 1'b0;
    assign take = start && !busy;

    // input value taken in its low bits, sign-extended if the store is wider
    assign new_value  = VALUE_WIDTH'(i_item.value);
    assign is_insert  = take && (i_item.kind == KIND_INSERT);
    assign is_extract = take && (i_item.kind == KIND_EXTRACT);

    // insert into full store and extract from empty store leave the chain alone
    assign cmd.ins = is_insert  && (r_count != FULL_COUNT);
    assign cmd.ext = is_extract && (r_count != '0);

    // ---- chain of cells ----
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] left_value;
        logic                   left_ge;
        logic [VALUE_WIDTH-1:0] right_value;
        logic                   occupied;

        assign occupied = (CW'(g) < r_count);

        if (g == 0) begin : g_head
            // nothing to the left of the head: it never takes a shifted entry
            assign left_value = new_value;
            assign left_ge    = 1'b0;
        end else begin : g_body
            assign left_value = cell_value[g-1];
            assign left_ge    = cell_ge[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            // tail entry becomes unoccupied on extract, its contents do not matter
            assign right_value = cell_value[g];
        end else begin : g_mid
            assign right_value = cell_value[g+1];
        end

        smpq_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_cmd         (cmd),
            .i_new_value   (new_value),
            .i_occupied    (occupied),
            .i_left_value  (left_value),
            .i_left_ge     (left_ge),
            .i_right_value (right_value),
            .o_value       (cell_value[g]),
            .o_ge          (cell_ge[g])
        );
    end

    // ---- count ----
    always_comb begin
        n_count = r_count;
        if (cmd.ins) begin
            n_count = r_count + CW'(1);
        end else if (cmd.ext) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= take;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_removed       <= cmd.ext ? cell_value[0] : '0;
            r_removed_valid <= cmd.ext;
            r_overflow      <= is_insert && (r_count == FULL_COUNT);
        end
    end

    // ---- result beat ----
    // the head cell and count already hold the post-step state while the strobe is up
    assign o_result_valid          = r_strobe;
    assign o_result.removed_value  = FIELD_W'(r_removed);
    assign o_result.removed_valid  = r_removed_valid;
    assign o_result.min_value      = (r_count != '0) ? FIELD_W'(cell_value[0]) : '0;
    assign o_result.is_empty       = (r_count == '0);
    assign o_result.entry_count    = COUNT_FIELD_W'(r_count);
    assign o_result.overflow       = r_overflow;

    // ---- assertions ----
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count beyond depth");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_insert && r_count == FULL_COUNT) |=> (r_count == FULL_COUNT && o_result.overflow))
        else $error("insert into full store changed the count or missed overflow");

    a_extract_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_extract && r_count != '0) |=> (r_count == $past(r_count) - CW'(1)
            && o_result.removed_valid))
        else $error("extract did not remove exactly one entry");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !(o_result.removed_valid && o_result.overflow))
        else $error("removed and overflow set together");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_insert && r_count == '0) |=> (cell_value[0] == $past(new_value)))
        else $error("insert into empty store not at head");

endmodule

`default_nettype wire

@@ src/smpq_cell.sv @@
// one cell of the sorted chain: holds one entry and shifts with its neighbours
`default_nettype none

module smpq_cell #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire                         i_clk,
    input  smpq_pkg::t_cell_cmd         i_cmd,
    input  wire [VALUE_WIDTH-1:0]       i_new_value,
    input  wire                         i_occupied,
    input  wire [VALUE_WIDTH-1:0]       i_left_value,
    input  wire                         i_left_ge,
    input  wire [VALUE_WIDTH-1:0]       i_right_value,
    output logic [VALUE_WIDTH-1:0]      o_value,
    output logic                        o_ge
);
    import smpq_pkg::*;

    logic [VALUE_WIDTH-1:0] r_value;

    // an empty slot counts as above everything, so the new value lands there
    assign o_ge    = !i_occupied || ($signed(r_value) >= $signed(i_new_value));
    assign o_value = r_value;

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.ins) begin
            priority if (i_left_ge) begin
                r_value <= i_left_value;
            end else if (o_ge) begin
                r_value <= i_new_value;
            end else begin
                // entry below the insert point stays put
                r_value <= r_value;
            end
        end else if (i_cmd.ext) begin
            r_value <= i_right_value;
        end else begin
            r_value <= r_value;
        end
    end

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// self-checking testbench for the sorted minimum priority queue
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import smpq_pkg::*;

    localparam int QDEPTH      = 16;
    localparam int CYCLE_LIMIT = 200000;

    // shadow copy of the queue: predicts every result beat and checks what comes back
    class min_queue_shadow;
        logic signed [FIELD_W-1:0] entries [QDEPTH];
        int        held;
        t_out_item awaited_status [$];
        int        mismatches;
        int        inserts;
        int        extracts;
        int        overflows;
        int        empty_extracts;
        int        full_hits;

        function new();
            held           = 0;
            mismatches     = 0;
            inserts        = 0;
            extracts       = 0;
            overflows      = 0;
            empty_extracts = 0;
            full_hits      = 0;
        endfunction

        function int pending();
            return awaited_status.size();
        endfunction

        task report_mismatch(input string what, input logic [FIELD_W-1:0] got,
                             input logic [FIELD_W-1:0] want);
            $display("error at %0t: %s got %h want %h", $realtime, what, got, want);
            mismatches++;
        endtask

        // apply one accepted command beat to the shadow and queue its status
        function void note_command(input t_in_item item);
            t_out_item                  status;
            logic signed [FIELD_W-1:0]  v;
            int                         pos;
            status = '0;
            v      = item.value;
            if (item.kind == KIND_INSERT) begin
                inserts++;
                if (held >= QDEPTH) begin
                    // full: value dropped, nothing moves
                    status.overflow = 1'b1;
                    overflows++;
                end else begin
                    // new value lands ahead of any equal entries
                    pos = 0;
                    while (pos < held && $signed(entries[pos]) < $signed(v))
                        pos++;
                    for (int i = held; i > pos; i--)
                        entries[i] = entries[i-1];
                    entries[pos] = v;
                    held++;
                    if (held == QDEPTH)
                        full_hits++;
                end
            end else begin
                extracts++;
                if (held > 0) begin
                    status.removed_value = entries[0];
                    status.removed_valid = 1'b1;
                    for (int i = 1; i < held; i++)
                        entries[i-1] = entries[i];
                    held--;
                end else begin
                    empty_extracts++;
                end
            end
            status.min_value   = (held > 0) ? entries[0] : '0;
            status.is_empty    = (held == 0);
            status.entry_count = COUNT_FIELD_W'(held);
            awaited_status.push_back(status);
        endfunction

        task check_status(input t_out_item got);
            t_out_item want;
            if (awaited_status.size() == 0) begin
                report_mismatch("unexpected result beat, count", 32'(got.entry_count), '0);
            end else begin
                want = awaited_status.pop_front();
                if (got.removed_value !== want.removed_value)
                    report_mismatch("removed_value", got.removed_value, want.removed_value);
                if (got.removed_valid !== want.removed_valid)
                    report_mismatch("removed_valid", 32'(got.removed_valid),
                                    32'(want.removed_valid));
                if (got.min_value !== want.min_value)
                    report_mismatch("min_value", got.min_value, want.min_value);
                if (got.is_empty !== want.is_empty)
                    report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
                if (got.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 32'(got.entry_count),
                                    32'(want.entry_count));
                if (got.overflow !== want.overflow)
                    report_mismatch("overflow", 32'(got.overflow), 32'(want.overflow));
            end
        endtask

        // anything still queued at the end never came back
        task flush_leftovers();
            t_out_item want;
            while (awaited_status.size() != 0) begin
                want = awaited_status.pop_front();
                report_mismatch("missing result beat, count", 'x, 32'(want.entry_count));
            end
        endtask
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_result_valid;
    t_out_item o_result;

    int        cycle_count = 0;

    min_queue_shadow shadow = new();

    sorted_min_priority_queue #(
        .DEPTH       (QDEPTH),
        .VALUE_WIDTH (FIELD_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // monitor: inputs change on the falling edge, so the rising edge sees them settled;
    // the result beat is checked before the command beat of the same edge is noted, so
    // a result can never be matched to the command taken at that very edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid)
                shadow.check_status(o_result);
            if (start && !busy)
                shadow.note_command(i_item);
        end
    end

    // one command beat; called just after a falling edge, returns just after one.
    // start stays high into the next call, so it is never lowered and raised in one step
    task automatic issue_command(input logic kind, input logic signed [FIELD_W-1:0] value);
        t_in_item item;
        item.kind  = kind;
        item.value = value;
        start  <= 1'b1;
        i_item <= item;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // an idle step: start low with junk on the payload
    task automatic idle_cycle();
        t_in_item junk;
        junk.kind  = 1'($urandom);
        junk.value = $urandom;
        start  <= 1'b0;
        i_item <= junk;
        @(negedge i_clk);
    endtask

    // sender holds off until the queue has answered everything sent so far
    task automatic hold_until_drained();
        start <= 1'b0;
        @(negedge i_clk);
        while (shadow.pending() != 0)
            @(negedge i_clk);
    endtask

    // mostly full-range values, with clusters of small ones to force ties
    function automatic logic signed [FIELD_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5)
            return $urandom;
        else if (sel < 8)
            return $signed($urandom_range(8)) - 4;
        else begin
            case ($urandom_range(3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7fff_ffff;
                2:       return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
    endfunction

    // random commands; the insert bias changes every 40 beats so the queue swings
    // between empty and full, with ties and overflow along the way
    task automatic run_random_phase(input int n_items, input int idle_pct);
        int   bias;
        logic kind;
        bias = 50;
        for (int k = 0; k < n_items; k++) begin
            if (k % 40 == 0) begin
                case ($urandom_range(2))
                    0:       bias = 85;
                    1:       bias = 50;
                    default: bias = 15;
                endcase
            end
            while ($urandom_range(99) < idle_pct)
                idle_cycle();
            kind = ($urandom_range(99) < bias) ? KIND_INSERT : KIND_EXTRACT;
            issue_command(kind, pick_value());
        end
    endtask

    // stuck run guard
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extract on an empty queue, extremes, equal values
        issue_command(KIND_EXTRACT, 32'sh5a5a_5a5a);
        issue_command(KIND_INSERT, 32'sh7fff_ffff);
        issue_command(KIND_INSERT, 32'sh8000_0000);
        issue_command(KIND_INSERT, 32'sh0000_0000);
        issue_command(KIND_INSERT, -32'sd1);
        issue_command(KIND_INSERT, 32'sh0000_0000);
        issue_command(KIND_EXTRACT, 32'shffff_ffff);
        // fill to capacity, a duplicate of the top value among them
        issue_command(KIND_INSERT, 32'sh7fff_ffff);
        for (int i = 0; i < 11; i++)
            issue_command(KIND_INSERT, (i % 2) ? 32'(i * 37) : -32'(i * 1000));
        // insert into a full queue is refused
        issue_command(KIND_INSERT, 32'sh1234_5678);
        issue_command(KIND_EXTRACT, '0);
        issue_command(KIND_EXTRACT, '0);
        hold_until_drained();

        // random phases: full rate twice, sender idling hard, full rate again (the receiver
        // cannot stall, so its phase runs at full rate), then light sender idling
        run_random_phase(105, 0);
        hold_until_drained();
        run_random_phase(105, 0);
        hold_until_drained();
        run_random_phase(210, 74);
        hold_until_drained();
        run_random_phase(210, 0);
        hold_until_drained();
        run_random_phase(210, 13);

        hold_until_drained();
        repeat (4) @(negedge i_clk);
        shadow.flush_leftovers();

        $display("covered %0d command beats: %0d inserts, %0d extracts",
                 shadow.inserts + shadow.extracts, shadow.inserts, shadow.extracts);
        $display("queue full %0d times, %0d inserts refused, %0d extracts on an empty queue",
                 shadow.full_hits, shadow.overflows, shadow.empty_extracts);
        if (shadow.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
src/smpq_pkg.sv
src/smpq_cell.sv
src/sorted_min_priority_queue.sv
sim/testbench.sv
